// ===== design/ist_pkg.sv =====
// Package for the integer set table: sizes, command and status codes,
// and the control word shared by the top level and the storage cells.
// No dependencies.
package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_PRESENT  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic                    load;
		logic                    ins;
		logic                    del;
		logic signed [KEY_W-1:0] key;
	} cell_ctl_t;

endpackage

// ===== design/ist_cmd_if.sv =====
// Command channel of the integer set table: valid/ready and one command word.
// Depends on ist_pkg.
interface ist_cmd_if import ist_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface

// ===== design/ist_res_if.sv =====
// Result channel of the integer set table: valid/ready and one result word.
// Depends on ist_pkg.
interface ist_res_if import ist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             found;
	logic [CNT_W-1:0] element_count;
	logic             is_empty;

	modport source (output valid, output status, output found, output element_count,
		output is_empty, input ready);
	modport sink (input valid, input status, input found, input element_count,
		input is_empty, output ready);
endinterface

// ===== design/ist_cell.sv =====
// One storage cell of the set table: holds a key, compares it against the
// broadcast key and takes its neighbour's key when a delete closes the gap.
// Depends on ist_pkg.
module ist_cell import ist_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic                    live,
	input  logic                    wr_sel,
	input  logic                    hit_in,
	input  logic signed [KEY_W-1:0] next_slot,
	output logic                    hit_out,
	output logic                    match,
	output logic signed [KEY_W-1:0] slot
);

	logic                    match_q;
	logic signed [KEY_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.load) begin
			match_q <= live && (slot_q == ctl.key);
		end
	end

	// the hit travels up the row: every cell at or above the match shifts down
	assign hit_out = hit_in | match_q;

	always_ff @(posedge clk) begin
		if (ctl.del && hit_out) begin
			slot_q <= next_slot;
		end else if (ctl.ins && wr_sel) begin
			slot_q <= ctl.key;
		end
	end

	assign match = match_q;
	assign slot  = slot_q;

endmodule

// ===== design/integer_set_table.sv =====
// Integer set table: a packed set of up to CAPACITY distinct signed 32-bit keys
// kept in a row of cells. In the cycle a command word is accepted all cells
// compare their key against it at once; in the exec state the hit runs along
// the row and the table is updated (append at the fill position, or every
// cell above a deleted key takes its upper neighbour's key). The result lands
// in an output register; while that register still holds an untaken result
// the update waits. A new command is taken whenever no command is in flight.
// Depends on ist_pkg, ist_cmd_if, ist_res_if, ist_cell.
module integer_set_table import ist_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ist_cmd_if.sink     req,
	ist_res_if.source   rsp
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    rsp_valid_q;
	logic [1:0]              status_q;
	logic                    found_q;
	logic [CNT_W-1:0]        count_q;
	logic                    empty_q;

	logic                    accept;
	logic                    commit;
	logic                    found;
	logic                    full;
	logic                    ins_ok;
	logic                    del_ok;
	logic [1:0]              status_d;
	logic [CNT_W-1:0]        fill_d;
	cell_ctl_t               ctl;

	logic                    hit [CAPACITY+1];
	logic [CAPACITY-1:0]     match_vec;
	logic signed [KEY_W-1:0] slot_w [CAPACITY];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	assign found  = hit[CAPACITY];
	assign full   = (fill_q == CNT_W'(CAPACITY));
	assign ins_ok = (cmd_q == CMD_INSERT) && !found && !full;
	assign del_ok = (cmd_q == CMD_DELETE) && found;

	always_comb begin
		case (cmd_q)
			CMD_INSERT: status_d = found ? ST_PRESENT : (full ? ST_FULL : ST_DONE);
			CMD_DELETE: status_d = found ? ST_DONE : ST_NOTFOUND;
			CMD_QUERY:  status_d = found ? ST_DONE : ST_NOTFOUND;
			default:    status_d = found ? ST_DONE : ST_NOTFOUND;
		endcase
		if (ins_ok) begin
			fill_d = fill_q + 1'b1;
		end else if (del_ok) begin
			fill_d = fill_q - 1'b1;
		end else begin
			fill_d = fill_q;
		end
	end

	// compare against the incoming key, update with the held one
	assign ctl.load = accept;
	assign ctl.ins  = commit && ins_ok;
	assign ctl.del  = commit && del_ok;
	assign ctl.key  = (state_q == S_IDLE) ? req.key : key_q;

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic signed [KEY_W-1:0] next_slot;

		if (i == CAPACITY - 1) begin : g_last
			assign next_slot = slot_w[i];
		end else begin : g_mid
			assign next_slot = slot_w[i+1];
		end

		ist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.live      (IDX < fill_q),
			.wr_sel    (IDX == fill_q),
			.hit_in    (hit[i]),
			.next_slot (next_slot),
			.hit_out   (hit[i+1]),
			.match     (match_vec[i]),
			.slot      (slot_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				fill_q      <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			key_q <= req.key;
		end
		if (commit) begin
			status_q <= status_d;
			found_q  <= found;
			count_q  <= fill_d;
			empty_q  <= (fill_d == '0);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.found         = found_q;
	assign rsp.element_count = count_q;
	assign rsp.is_empty      = empty_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(match_vec))
		else $error("key stored in more than one cell");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (rsp.valid && rsp.element_count == fill_q))
		else $error("result word not presented after update");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (rsp.element_count == '0)))
		else $error("empty flag disagrees with count");

endmodule
